### src/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg: shared types and constants for the ordered list engine
// Node store size, command and status codes, sequencer states and the
// control bundle between the list sequencer and the slot map.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_KEY    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK   = 3'd5;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOKEY = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_BWALK,
    S_HEAD_RD,
    S_UNLINK,
    S_FRONT_LD,
    S_INS,
    S_LINK_WR,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    INS_FRONT,
    INS_BACK,
    INS_AFTER
  } ins_mode_t;

  typedef struct packed {
    logic              claim;
    logic              release_en;
    logic [SLOT_W-1:0] release_slot;
  } slot_ctl_t;

endpackage

### src/ole_slot_map.sv
// ----------------------------------------------------------------------------
// ole_slot_map: free-slot map of the node store
// Holds one free flag per slot and offers the lowest-numbered free slot.
// ----------------------------------------------------------------------------
module ole_slot_map (
  input  logic                      clk,
  input  logic                      rst,
  input  ole_pkg::slot_ctl_t        ctl,
  output logic [ole_pkg::SLOT_W-1:0] free_slot
);
  import ole_pkg::*;

  logic [CAPACITY-1:0] free_map;

  // Lowest set flag wins: scan down so the last hit is the lowest.
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
    end else begin
      if (ctl.claim) begin
        free_map[free_slot] <= 1'b0;
      end
      if (ctl.release_en) begin
        free_map[ctl.release_slot] <= 1'b1;
      end
    end
  end

  a_claim_free: assert property (@(posedge clk) disable iff (rst)
    ctl.claim |-> free_map[free_slot])
    else $error("claimed slot is not free");

  a_release_used: assert property (@(posedge clk) disable iff (rst)
    ctl.release_en |-> !free_map[ctl.release_slot])
    else $error("released slot was already free");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ctl.claim && ctl.release_en))
    else $error("claim and release in one cycle");

endmodule

### src/ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_top: circular singly linked list of signed values
// Node values and links live in two stores with one write and one read port each; a small sequencer
// walks the list one node per cycle through a shared compare unit.
// ----------------------------------------------------------------------------
// Refused commands, front/back inserts and front deletes do not walk the list; key
// search and delete-back walk it node by node, up to CAPACITY nodes, one node read
// per cycle.
// One transaction at a time: busy stays high from accept through done, and the
// next transaction is taken in the cycle after done.
// Synchronous reset empties the list and frees every slot; done cannot be held off.
// ----------------------------------------------------------------------------
module ordered_list_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] match_key,
  input  logic signed [31:0] new_value,
  output logic               busy,
  output logic               done,
  output logic [1:0]         status,
  output logic [4:0]         entry_count,
  output logic signed [31:0] front_value,
  output logic signed [31:0] back_value,
  output logic signed [31:0] removed_value
);
  import ole_pkg::*;

  // node stores
  logic [DATA_W-1:0] val_mem  [CAPACITY];
  logic [SLOT_W-1:0] link_mem [CAPACITY];
  logic [DATA_W-1:0] rd_val;
  logic [SLOT_W-1:0] rd_link;
  logic [SLOT_W-1:0] rd_addr;
  logic              val_we;
  logic              link_we;
  logic [SLOT_W-1:0] link_wa;
  logic [SLOT_W-1:0] link_wd;

  state_t state, state_next;

  // list state
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] front_val;
  logic [DATA_W-1:0] back_val;

  // transaction registers
  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] val_q;
  status_t           status_q;
  logic [DATA_W-1:0] removed_q;
  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] prev;
  logic [DATA_W-1:0] prev_val;
  logic [SLOT_W-1:0] nxt;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] fix_addr;
  logic [SLOT_W-1:0] fix_data;
  ins_mode_t         ins_mode;

  logic              full;
  logic              empty;
  logic              single;
  logic              last;
  logic [DATA_W-1:0] cmp_a;
  logic [DATA_W-1:0] cmp_b;
  logic              hit;
  status_t           dispatch_status;
  logic [SLOT_W-1:0] free_slot;
  slot_ctl_t         slot_ctl;

  assign full   = (count == CNT_W'(CAPACITY));
  assign empty  = (count == '0);
  assign single = (count == CNT_W'(1));
  assign last   = ((CNT_W'(idx) + CNT_W'(1)) == count);

  // Shared compare unit: value against key on a key walk, link against tail
  // on the walk to the node before the tail.
  always_comb begin
    if (state == S_BWALK) begin
      cmp_a = DATA_W'(rd_link);
      cmp_b = DATA_W'(tail);
    end else begin
      cmp_a = rd_val;
      cmp_b = key_q;
    end
  end
  assign hit = (cmp_a == cmp_b);

  always_comb begin
    dispatch_status = ST_DONE;
    unique case (cmd_q)
      CMD_INS_FRONT, CMD_APPEND: begin
        if (full) dispatch_status = ST_FULL;
      end
      CMD_INS_BEFORE: begin
        if (full) dispatch_status = ST_FULL;
        else if (empty) dispatch_status = ST_NOKEY;
      end
      CMD_DEL_KEY, CMD_DEL_FRONT, CMD_DEL_BACK: begin
        if (empty) dispatch_status = ST_EMPTY;
      end
      default: dispatch_status = ST_DONE;
    endcase
  end

  ole_slot_map u_slot_map (
    .clk       (clk),
    .rst       (rst),
    .ctl       (slot_ctl),
    .free_slot (free_slot)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (dispatch_status != ST_DONE) begin
          state_next = S_DONE;
        end else begin
          unique case (cmd_q)
            CMD_INS_FRONT, CMD_APPEND:   state_next = S_INS;
            CMD_INS_BEFORE, CMD_DEL_KEY: state_next = S_WALK;
            CMD_DEL_FRONT:               state_next = S_HEAD_RD;
            CMD_DEL_BACK:                state_next = single ? S_UNLINK : S_BWALK;
            default:                     state_next = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        if (hit) state_next = (cmd_q == CMD_DEL_KEY) ? S_UNLINK : S_INS;
        else if (last) state_next = S_DONE;
      end
      S_BWALK: begin
        if (hit) state_next = S_UNLINK;
      end
      S_HEAD_RD:  state_next = S_UNLINK;
      S_UNLINK: begin
        if (!single && !empty && cur == head) state_next = S_FRONT_LD;
        else state_next = S_DONE;
      end
      S_FRONT_LD: state_next = S_DONE;
      S_INS: begin
        if (ins_mode == INS_FRONT && empty) state_next = S_DONE;
        else state_next = S_LINK_WR;
      end
      S_LINK_WR:  state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // store ports and slot map control
  always_comb begin
    rd_addr               = cur;
    val_we                = 1'b0;
    link_we               = 1'b0;
    link_wa               = free_slot;
    link_wd               = head;
    slot_ctl.claim        = 1'b0;
    slot_ctl.release_en   = 1'b0;
    slot_ctl.release_slot = cur;
    unique case (state)
      S_DISPATCH: rd_addr = head;
      // advance the walk: the next node's read goes out this cycle
      S_WALK, S_BWALK: rd_addr = rd_link;
      S_UNLINK: begin
        rd_addr             = nxt;
        slot_ctl.release_en = 1'b1;
        if (!single && !empty) begin
          link_we = 1'b1;
          link_wd = nxt;
          link_wa = (cur == head) ? tail : prev;
        end
      end
      S_INS: begin
        val_we         = 1'b1;
        link_we        = 1'b1;
        slot_ctl.claim = 1'b1;
        link_wa        = free_slot;
        unique case (ins_mode)
          INS_FRONT: link_wd = empty ? free_slot : head;
          INS_BACK:  link_wd = head;
          INS_AFTER: link_wd = cur;
          default:   link_wd = head;
        endcase
      end
      S_LINK_WR: begin
        link_we = 1'b1;
        link_wa = fix_addr;
        link_wd = fix_data;
      end
      default: rd_addr = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[free_slot] <= val_q;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    rd_val  <= val_mem[rd_addr];
    rd_link <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            key_q <= match_key;
            val_q <= new_value;
          end
        end
        S_DISPATCH: begin
          status_q <= dispatch_status;
          cur      <= head;
          prev     <= tail;
          prev_val <= back_val;
          idx      <= '0;
          ins_mode <= (cmd_q == CMD_APPEND && !empty) ? INS_BACK : INS_FRONT;
          if (empty) removed_q <= '0;
          else if (cmd_q == CMD_DEL_FRONT) removed_q <= front_val;
          else if (cmd_q == CMD_DEL_BACK) removed_q <= back_val;
          else removed_q <= '0;
        end
        S_WALK: begin
          if (hit) begin
            nxt <= rd_link;
            if (cmd_q == CMD_DEL_KEY) removed_q <= rd_val;
            ins_mode <= (cur == head) ? INS_FRONT : INS_AFTER;
          end else if (last) begin
            status_q <= ST_NOKEY;
          end else begin
            prev     <= cur;
            prev_val <= rd_val;
            cur      <= rd_link;
            idx      <= idx + SLOT_W'(1);
          end
        end
        S_BWALK: begin
          if (hit) begin
            prev     <= cur;
            prev_val <= rd_val;
            cur      <= tail;
            nxt      <= head;
          end else begin
            cur <= rd_link;
          end
        end
        S_HEAD_RD: nxt <= rd_link;
        S_UNLINK: begin
          if (single || empty) begin
            head  <= '0;
            tail  <= '0;
            count <= '0;
          end else begin
            count <= count - CNT_W'(1);
            if (cur == head) begin
              head <= nxt;
            end else if (cur == tail) begin
              tail     <= prev;
              back_val <= prev_val;
            end
          end
        end
        S_FRONT_LD: front_val <= rd_val;
        S_INS: begin
          count    <= count + CNT_W'(1);
          fix_data <= free_slot;
          unique case (ins_mode)
            INS_FRONT: begin
              head      <= free_slot;
              front_val <= val_q;
              fix_addr  <= tail;
              if (empty) begin
                tail     <= free_slot;
                back_val <= val_q;
              end
            end
            INS_BACK: begin
              tail     <= free_slot;
              back_val <= val_q;
              fix_addr <= tail;
            end
            INS_AFTER: fix_addr <= prev;
            default:   fix_addr <= prev;
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign busy          = (state != S_IDLE);
  assign done          = (state == S_DONE);
  assign status        = status_q;
  assign entry_count   = COUNT_W'(count);
  assign front_value   = empty ? '0 : front_val;
  assign back_value    = empty ? '0 : back_val;
  assign removed_value = removed_q;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("node count above capacity");

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy after result");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status_q == ST_FULL) |-> full)
    else $error("full status on a list with room");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transaction did not start");

endmodule
